FILE: rtl/flc_word_delta_decoder_top_defines.svh
// assertion macros for the word delta decoder
`ifndef FLC_WORD_DELTA_DECODER_TOP_DEFINES_SVH
`define FLC_WORD_DELTA_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on clk while out of reset
`define FLCWD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define FLCWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define FLCWD_ASSERT_SAME(label, ante, cons, msg)
`define FLCWD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/flcwd_pkg.sv
// shared types and constants of the word delta decoder
package flcwd_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_X_ORIGIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_ORIGIN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECT_WIDTH = 2'd2;

  // configuration reset values
  localparam logic [15:0] X_ORIGIN_RST   = 16'd0;
  localparam logic [15:0] Y_ORIGIN_RST   = 16'd0;
  localparam logic [15:0] RECT_WIDTH_RST = 16'd320;

  // opcode word flags
  localparam int SignBit = 15;
  localparam int SkipBit = 14;

  typedef struct packed {
    logic [15:0] x_origin;
    logic [15:0] y_origin;
    logic [15:0] rect_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [8:0]  run_length;
    logic [7:0]  pixel_even;
    logic [7:0]  pixel_odd;
    logic        chunk_done;
  } res_t;

endpackage

FILE: rtl/flcwd_if.sv
// request channel interfaces: compressed byte input and pixel result output
interface flcwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;

  modport source (output valid, data_byte, chunk_start, input ready);
  modport sink   (input valid, data_byte, chunk_start, output ready);
endinterface

interface flcwd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [8:0]  run_length;
  logic [7:0]  pixel_even;
  logic [7:0]  pixel_odd;
  logic        chunk_done;

  modport source (output valid, pos_x, pos_y, run_length, pixel_even, pixel_odd,
                  chunk_done, input ready);
  modport sink   (input valid, pos_x, pos_y, run_length, pixel_even, pixel_odd,
                  chunk_done, output ready);
endinterface

FILE: rtl/flcwd_cfg_regs.sv
// configuration registers of the word delta decoder
module flcwd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [flcwd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output flcwd_pkg::cfg_t                cfg
);

  flcwd_pkg::cfg_t cfg_r;

  // register writes, unused index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin   <= flcwd_pkg::X_ORIGIN_RST;
      cfg_r.y_origin   <= flcwd_pkg::Y_ORIGIN_RST;
      cfg_r.rect_width <= flcwd_pkg::RECT_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flcwd_pkg::CFG_X_ORIGIN:   cfg_r.x_origin   <= cfg_wdata;
        flcwd_pkg::CFG_Y_ORIGIN:   cfg_r.y_origin   <= cfg_wdata;
        flcwd_pkg::CFG_RECT_WIDTH: cfg_r.rect_width <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/flcwd_in_stage.sv
// input register stage: holds one accepted byte until the parser takes it
module flcwd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  flcwd_in_if.sink            in_ch,
  input  logic                take,
  output logic                item_valid,
  output flcwd_pkg::in_item_t item
);

  logic                valid_r;
  flcwd_pkg::in_item_t item_r;
  logic                accept;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte   <= in_ch.data_byte;
      item_r.chunk_start <= in_ch.chunk_start;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/flcwd_parser.sv
// chunk parser: per-byte state update and result forming
module flcwd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  flcwd_pkg::in_item_t item,
  input  flcwd_pkg::cfg_t     cfg,
  output logic                res_valid,
  output flcwd_pkg::res_t     res
);

  typedef enum logic [10:0] {
    PH_LC_LO  = 11'b000_0000_0001,
    PH_LC_HI  = 11'b000_0000_0010,
    PH_OP_LO  = 11'b000_0000_0100,
    PH_OP_HI  = 11'b000_0000_1000,
    PH_PC_LO  = 11'b000_0001_0000,
    PH_PC_HI  = 11'b000_0010_0000,
    PH_SKIP   = 11'b000_0100_0000,
    PH_CNT    = 11'b000_1000_0000,
    PH_LIT    = 11'b001_0000_0000,
    PH_RUN_LO = 11'b010_0000_0000,
    PH_RUN_HI = 11'b100_0000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] lines_r, lines_nxt;
  logic [15:0] pkts_r, pkts_nxt;
  logic [8:0]  lit_r, lit_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic        fin_r, fin_nxt, fin_eff;

  logic [7:0]  b;
  logic [15:0] word;
  logic [15:0] pkts_dec;
  logic [8:0]  lit_dec;
  logic [7:0]  neg_b;
  logic        end_pkt, end_line, done;

  assign b        = item.data_byte;
  assign word     = {b, low_r};
  assign pkts_dec = pkts_r - 16'd1;
  assign lit_dec  = lit_r - 9'd1;
  assign neg_b    = 8'd0 - b;

  // one parse step
  always_comb begin
    phase_eff = item.chunk_start ? PH_LC_LO : phase_r;
    fin_eff   = item.chunk_start ? 1'b0 : fin_r;
    phase_nxt = phase_eff;
    fin_nxt   = fin_eff;
    low_nxt   = low_r;
    lines_nxt = lines_r;
    pkts_nxt  = pkts_r;
    lit_nxt   = lit_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    res_valid = 1'b0;
    res       = '0;
    end_pkt   = 1'b0;
    end_line  = 1'b0;
    done      = 1'b0;

    if (!fin_eff) begin
      unique case (phase_eff)
        PH_LC_LO: begin
          low_nxt   = b;
          phase_nxt = PH_LC_HI;
        end
        PH_OP_LO: begin
          low_nxt   = b;
          phase_nxt = PH_OP_HI;
        end
        PH_PC_LO: begin
          low_nxt   = b;
          phase_nxt = PH_PC_HI;
        end
        PH_LC_HI: begin
          lines_nxt = word;
          y_nxt     = cfg.y_origin;
          phase_nxt = PH_OP_LO;
        end
        PH_OP_HI: begin
          if (!word[flcwd_pkg::SignBit]) begin
            // plain packet count
            if (word == 16'd0) begin
              end_line = 1'b1;
            end else begin
              pkts_nxt  = word;
              x_nxt     = cfg.x_origin;
              phase_nxt = PH_SKIP;
            end
          end else if (word[flcwd_pkg::SkipBit]) begin
            // line skip
            y_nxt     = y_r - word;
            phase_nxt = PH_OP_LO;
          end else begin
            // last pixel of the line, packet count follows
            phase_nxt      = PH_PC_LO;
            res_valid      = 1'b1;
            res.pos_x      = cfg.x_origin + cfg.rect_width - 16'd1;
            res.pos_y      = y_r;
            res.run_length = 9'd1;
            res.pixel_even = word[7:0];
          end
        end
        PH_PC_HI: begin
          if (word == 16'd0) begin
            end_line = 1'b1;
          end else begin
            pkts_nxt  = word;
            x_nxt     = cfg.x_origin;
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          x_nxt     = x_r + {8'd0, b};
          phase_nxt = PH_CNT;
        end
        PH_CNT: begin
          if (b == 8'd0) begin
            end_pkt = 1'b1;
          end else if (!b[7]) begin
            lit_nxt   = {b, 1'b0};
            phase_nxt = PH_LIT;
          end else begin
            lit_nxt   = {neg_b, 1'b0};
            phase_nxt = PH_RUN_LO;
          end
        end
        PH_LIT: begin
          res_valid      = 1'b1;
          res.pos_x      = x_r;
          res.pos_y      = y_r;
          res.run_length = 9'd1;
          res.pixel_even = b;
          x_nxt          = x_r + 16'd1;
          lit_nxt        = lit_dec;
          end_pkt        = (lit_dec == 9'd0);
        end
        PH_RUN_LO: begin
          low_nxt   = b;
          phase_nxt = PH_RUN_HI;
        end
        PH_RUN_HI: begin
          res_valid      = 1'b1;
          res.pos_x      = x_r;
          res.pos_y      = y_r;
          res.run_length = lit_r;
          res.pixel_even = low_r;
          res.pixel_odd  = b;
          x_nxt          = x_r + {7'd0, lit_r};
          lit_nxt        = 9'd0;
          end_pkt        = 1'b1;
        end
        default: ;
      endcase

      // packet close
      if (end_pkt) begin
        pkts_nxt = pkts_dec;
        if (pkts_dec == 16'd0) begin
          end_line = 1'b1;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end

      // line close, last line finishes the chunk
      if (end_line) begin
        y_nxt = y_nxt + 16'd1;
        if (lines_r <= 16'd1) begin
          lines_nxt = 16'd0;
          fin_nxt   = 1'b1;
          done      = 1'b1;
        end else begin
          lines_nxt = lines_r - 16'd1;
          phase_nxt = PH_OP_LO;
        end
      end

      // finishing byte without pixels gives a bare marker
      if (done && !res_valid) begin
        res_valid = 1'b1;
        res       = '0;
      end
      res.chunk_done = done;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LC_LO;
      low_r   <= 8'd0;
      lines_r <= 16'd0;
      pkts_r  <= 16'd0;
      lit_r   <= 9'd0;
      x_r     <= 16'd0;
      y_r     <= 16'd0;
      fin_r   <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      lines_r <= lines_nxt;
      pkts_r  <= pkts_nxt;
      lit_r   <= lit_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

FILE: rtl/flcwd_out_stage.sv
// result register stage feeding the output channel
module flcwd_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  flcwd_pkg::res_t res,
  output logic            can_load,
  flcwd_out_if.source     out_ch
);

  logic            valid_r;
  flcwd_pkg::res_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.pos_x      = res_r.pos_x;
  assign out_ch.pos_y      = res_r.pos_y;
  assign out_ch.run_length = res_r.run_length;
  assign out_ch.pixel_even = res_r.pixel_even;
  assign out_ch.pixel_odd  = res_r.pixel_odd;
  assign out_ch.chunk_done = res_r.chunk_done;

endmodule

FILE: rtl/flc_word_delta_decoder_top.sv
// top level of the word delta decoder
// Decodes a word-oriented delta chunk fed one byte per request and emits at
// most one pixel result per byte: a literal pixel, a two-byte run of up to 256
// pixels, or the last-pixel write of a line; a chunk that ends on a byte with
// no pixel gives one marker result with chunk_done set and all else zero.
// A byte with chunk_start set restarts the parser; bytes after the chunk ends
// are dropped without a result. One byte is taken every cycle while results
// are taken; a byte passes the input register and a combinational parse step,
// and its result is then held in the result register.
// Write the configuration registers only while the block is idle.
`include "flc_word_delta_decoder_top_defines.svh"

module flc_word_delta_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  flcwd_in_if.sink                       in_ch,
  flcwd_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [flcwd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata
);

  flcwd_pkg::cfg_t     cfg;
  flcwd_pkg::in_item_t item;
  flcwd_pkg::res_t     res;
  logic                item_valid;
  logic                can_load;
  logic                step_en;
  logic                res_valid;

  assign step_en = item_valid && can_load;

  flcwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  flcwd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  flcwd_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  flcwd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step_en && res_valid),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  // a bare marker carries nothing but chunk_done
  `FLCWD_ASSERT_SAME(a_marker_clean, out_ch.valid && (out_ch.run_length == 9'd0), out_ch.chunk_done && (out_ch.pos_x == 16'd0) && (out_ch.pos_y == 16'd0) && (out_ch.pixel_even == 8'd0) && (out_ch.pixel_odd == 8'd0), "marker result with nonzero fields")
  // run length stays in range
  `FLCWD_ASSERT_SAME(a_len_range, out_ch.valid, out_ch.run_length <= 9'd256, "run length above 256")
  // a held byte is not lost while the result side stalls
  `FLCWD_ASSERT_NEXT(a_in_hold, item_valid && !can_load, item_valid && $stable(item), "held input byte changed during stall")

endmodule
